@@ sv/vslerp_pkg.sv @@
// Shared constants, arctangent table and result type for the slerp pipeline
`timescale 1ns / 1ps
package vslerp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VEC_W = 20;
    localparam int FRAC_W = 17;
    localparam int IN_W = 144;
    localparam int OUT_W = 64;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CW = 34;
    localparam int RT_W = 31;
    localparam int RAD_W = 62;

    localparam logic signed [CW-1:0] PI_Q = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q = 34'sd1686629713;
    localparam logic signed [CW-1:0] TWO_PI_Q = 34'sd6746518852;
    localparam logic signed [CW-1:0] GAIN_Q = 34'sd652032874;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
        logic                    degen;
    } res_t;

    function automatic logic signed [CW-1:0] atan_q(input int step);
        logic signed [CW-1:0] v;
        case (step)
            0:  v = 34'sd843314856;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            24: v = 34'sd63;
            25: v = 34'sd31;
            26: v = 34'sd15;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/vslerp_cordic_cell.sv @@
// One CORDIC micro-rotation stage, vectoring or rotating
`timescale 1ns / 1ps
module vslerp_cordic_cell
    import vslerp_pkg::*;
#(
    parameter int STEP = 0,
    parameter bit VECTORING = 1'b0
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [CW-1:0] z_out
);

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] x_next, y_next, z_next;
    logic signed [CW-1:0] dx, dy;
    logic                 pos;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        pos = VECTORING ? (y_in <= 0) : (z_in >= 0);
        x_next = pos ? x_in - dx : x_in + dx;
        y_next = pos ? y_in + dy : y_in - dy;
        z_next = pos ? z_in - atan_q(STEP) : z_in + atan_q(STEP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

@@ sv/vslerp_sqrt_cell.sv @@
// One result bit of a pipelined integer square root
`timescale 1ns / 1ps
module vslerp_sqrt_cell
    import vslerp_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [RAD_W-1:0] rem_in,
    input  logic [RT_W-1:0]  root_in,
    output logic [RAD_W-1:0] rem_out,
    output logic [RT_W-1:0]  root_out
);

    logic [RAD_W-1:0] rem_reg, rem_next;
    logic [RT_W-1:0]  root_reg, root_next;
    logic [RAD_W:0]   trial;
    logic             take;

    always_comb
    begin
        trial = ((RAD_W+1)'(root_in) << (BIT + 1)) | ((RAD_W+1)'(1) << (2 * BIT));
        take = {1'b0, rem_in} >= trial;
        rem_next = take ? rem_in - trial[RAD_W-1:0] : rem_in;
        root_next = take ? (root_in | (RT_W'(1) << BIT)) : root_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out = rem_reg;
    assign root_out = root_reg;

endmodule

@@ sv/vslerp_div_cell.sv @@
// One quotient bit of three restoring dividers sharing a divisor
`timescale 1ns / 1ps
module vslerp_div_cell
    import vslerp_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [RT_W-1:0]  dv_in,
    input  logic [RAD_W-1:0] rem_in [0:2],
    input  logic [RT_W-1:0]  q_in [0:2],
    output logic [RT_W-1:0]  dv_out,
    output logic [RAD_W-1:0] rem_out [0:2],
    output logic [RT_W-1:0]  q_out [0:2]
);

    logic [RT_W-1:0]  dv_reg;
    logic [RAD_W-1:0] rem_reg [0:2];
    logic [RAD_W-1:0] rem_next [0:2];
    logic [RT_W-1:0]  q_reg [0:2];
    logic [RT_W-1:0]  q_next [0:2];
    logic [RAD_W-1:0] shd;

    always_comb
    begin
        shd = RAD_W'(dv_in) << BIT;
        for (int i = 0; i < 3; i++)
        begin
            if (rem_in[i] >= shd)
            begin
                rem_next[i] = rem_in[i] - shd;
                q_next[i] = q_in[i] | (RT_W'(1) << BIT);
            end
            else
            begin
                rem_next[i] = rem_in[i];
                q_next[i] = q_in[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg <= dv_in;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= rem_next[i];
                q_reg[i] <= q_next[i];
            end
        end
    end

    assign dv_out = dv_reg;
    assign rem_out = rem_reg;
    assign q_out = q_reg;

endmodule

@@ sv/vslerp_delay.sv @@
// Enabled shift line that keeps side data in step with the pipeline
`timescale 1ns / 1ps
module vslerp_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

@@ sv/vector_slerp.sv @@
// Spherical linear interpolation of 3D vectors: pipeline top level
//
// Input beats on s_* carry a start vector, an end vector and a fraction; each
// yields one output beat on m_* with the interpolated vector and a flag set
// when the relative vector had zero length. Both sides use tvalid/tready.
// One beat is taken every cycle while the output buffer has a free slot.
// The depth of the pipe is set by the longer of two paths: normalisation,
// with its square-root and quotient chains, and the angle path, with its
// square-root chain and two CORDIC chains.
// Every unit is a row of one-bit or one-step cells, all advancing together.
// A two-beat output buffer follows the last stage. The pipeline keeps
// advancing, and s_tready stays high, while the buffer has a free slot, so
// a stalled receiver holds the pipe only once two beats wait in it.
// Reset clears every valid bit and empties the buffer; the block accepts a
// beat as soon as reset is released.
`timescale 1ns / 1ps
module vector_slerp
    import vslerp_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, fraction, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // out_x, out_y, out_z, zero pad
    output logic [OUT_W-1:0] m_tdata,
    // degenerate
    output logic             m_tuser
);

    localparam int N = CORDIC_STEPS;
    localparam int LA = 42 + 2 * N;
    localparam int LR = 78;
    localparam int JN = ((LA > LR) ? LA : LR) + 1;
    localparam int TOT = JN + 3;
    localparam logic signed [41:0] ONE2 = 42'sd4294967296;

    logic           adv;
    logic [TOT-1:0] vld_reg;

    // front: capture, products, dot, clamp and round
    logic signed [VEC_W-1:0] s1_reg [0:2];
    logic signed [VEC_W-1:0] e1_reg [0:2];
    logic [FRAC_W-1:0]       f1_reg, f2_reg, f3_reg, f4_reg;
    logic signed [VEC_W-1:0] s2_reg [0:2];
    logic signed [VEC_W-1:0] e2_reg [0:2];
    logic signed [39:0]      pr2_reg [0:2];
    logic signed [VEC_W-1:0] s3_reg [0:2];
    logic signed [VEC_W-1:0] e3_reg [0:2];
    logic signed [41:0]      dot3_reg, dot_c;
    logic signed [VEC_W-1:0] s4_reg [0:2];
    logic signed [VEC_W-1:0] e4_reg [0:2];
    logic signed [31:0]      d4_reg;

    always_comb
    begin
        if (dot3_reg > ONE2)
            dot_c = ONE2;
        else if (dot3_reg < -ONE2)
            dot_c = -ONE2;
        else
            dot_c = dot3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_reg[i] <= s_tdata[i*VEC_W +: VEC_W];
                e1_reg[i] <= s_tdata[(i+3)*VEC_W +: VEC_W];
                pr2_reg[i] <= 40'(s1_reg[i]) * 40'(e1_reg[i]);
                s2_reg[i] <= s1_reg[i];
                e2_reg[i] <= e1_reg[i];
                s3_reg[i] <= s2_reg[i];
                e3_reg[i] <= e2_reg[i];
                s4_reg[i] <= s3_reg[i];
                e4_reg[i] <= e3_reg[i];
            end
            f1_reg <= s_tdata[6*VEC_W +: FRAC_W];
            f2_reg <= f1_reg;
            f3_reg <= f2_reg;
            f4_reg <= f3_reg;
            dot3_reg <= 42'(pr2_reg[0]) + 42'(pr2_reg[1]) + 42'(pr2_reg[2]);
            d4_reg <= 32'((dot_c + 42'sd2) >>> 2);
        end
    end

    // angle path: sine of the angle, from the dot product
    logic signed [63:0] dsq;
    logic [RAD_W-1:0]   dd5_reg;
    logic [RAD_W-1:0]   sq1_rem [0:RT_W];
    logic [RT_W-1:0]    sq1_root [0:RT_W];

    assign dsq = 64'(d4_reg) * 64'(d4_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
            dd5_reg <= dsq[RAD_W-1:0];
    end

    assign sq1_rem[0] = (RAD_W'(1) << 60) - dd5_reg;
    assign sq1_root[0] = '0;

    for (genvar j = 0; j < RT_W; j++)
    begin : g_sq1
        vslerp_sqrt_cell #(.BIT(RT_W - 1 - j)) u_sq (
            .clk      (clk),
            .en       (adv),
            .rem_in   (sq1_rem[j]),
            .root_in  (sq1_root[j]),
            .rem_out  (sq1_rem[j+1]),
            .root_out (sq1_root[j+1])
        );
    end

    logic signed [31:0] d36;

    vslerp_delay #(.WIDTH(32), .DEPTH(32)) u_d_dly (
        .clk (clk),
        .en  (adv),
        .d   (d4_reg),
        .q   (d36)
    );

    // arc cosine by vectoring
    logic signed [CW-1:0] vx [0:N];
    logic signed [CW-1:0] vy [0:N];
    logic signed [CW-1:0] vz [0:N];
    logic signed [CW-1:0] sn36;

    assign sn36 = CW'(sq1_root[RT_W]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (d36 < 0)
            begin
                vx[0] <= sn36;
                vy[0] <= -CW'(d36);
                vz[0] <= HALF_PI_Q;
            end
            else
            begin
                vx[0] <= CW'(d36);
                vy[0] <= sn36;
                vz[0] <= '0;
            end
        end
    end

    for (genvar j = 0; j < N; j++)
    begin : g_vec
        vslerp_cordic_cell #(.STEP(j), .VECTORING(1'b1)) u_vec (
            .clk   (clk),
            .en    (adv),
            .x_in  (vx[j]),
            .y_in  (vy[j]),
            .z_in  (vz[j]),
            .x_out (vx[j+1]),
            .y_out (vy[j+1]),
            .z_out (vz[j+1])
        );
    end

    logic [FRAC_W-1:0] f_ang;

    vslerp_delay #(.WIDTH(FRAC_W), .DEPTH(33 + N)) u_f_dly (
        .clk (clk),
        .en  (adv),
        .d   (f4_reg),
        .q   (f_ang)
    );

    // theta: scale, wrap and fold into the right half plane
    logic signed [51:0]   m_reg;
    logic signed [35:0]   th1_reg;
    logic signed [CW-1:0] th2_reg, th3_reg;
    logic                 flip3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg <= 52'(vz[N]) * 52'(signed'({1'b0, f_ang}));
            th1_reg <= 36'((m_reg + 52'sd32768) >>> FRAC_BITS);
            if (th1_reg < 0)
                th2_reg <= CW'(th1_reg + 36'(TWO_PI_Q));
            else if (th1_reg >= 36'(TWO_PI_Q))
                th2_reg <= CW'(th1_reg - 36'(TWO_PI_Q));
            else
                th2_reg <= CW'(th1_reg);
            if (th2_reg <= HALF_PI_Q)
            begin
                th3_reg <= th2_reg;
                flip3_reg <= 1'b0;
            end
            else if (th2_reg < TWO_PI_Q - HALF_PI_Q)
            begin
                th3_reg <= th2_reg - PI_Q;
                flip3_reg <= 1'b1;
            end
            else
            begin
                th3_reg <= th2_reg - TWO_PI_Q;
                flip3_reg <= 1'b0;
            end
        end
    end

    logic signed [CW-1:0] rx [0:N];
    logic signed [CW-1:0] ry [0:N];
    logic signed [CW-1:0] rz [0:N];

    assign rx[0] = GAIN_Q;
    assign ry[0] = '0;
    assign rz[0] = th3_reg;

    for (genvar j = 0; j < N; j++)
    begin : g_rot
        vslerp_cordic_cell #(.STEP(j), .VECTORING(1'b0)) u_rot (
            .clk   (clk),
            .en    (adv),
            .x_in  (rx[j]),
            .y_in  (ry[j]),
            .z_in  (rz[j]),
            .x_out (rx[j+1]),
            .y_out (ry[j+1]),
            .z_out (rz[j+1])
        );
    end

    logic flip_r;

    vslerp_delay #(.WIDTH(1), .DEPTH(N)) u_flip_dly (
        .clk (clk),
        .en  (adv),
        .d   (flip3_reg),
        .q   (flip_r)
    );

    logic signed [CW-1:0] cs_reg, sv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cs_reg <= flip_r ? -rx[N] : rx[N];
            sv_reg <= flip_r ? -ry[N] : ry[N];
        end
    end

    // relative vector path
    logic signed [51:0]   p5_reg [0:2];
    logic signed [VEC_W-1:0] e5_reg [0:2];
    logic signed [51:0]   rel6_reg [0:2];
    logic signed [51:0]   lad_r_reg [0:5][0:2];
    logic [50:0]          lad_m_reg [0:5];
    logic [50:0]          m7_next;
    logic signed [51:0]   ab6 [0:2];

    always_comb
    begin
        m7_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            ab6[i] = (rel6_reg[i] < 0) ? -rel6_reg[i] : rel6_reg[i];
            m7_next = m7_next | ab6[i][50:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p5_reg[i] <= 52'(s4_reg[i]) * 52'(d4_reg);
                e5_reg[i] <= e4_reg[i];
                rel6_reg[i] <= (52'(e5_reg[i]) <<< 30) - p5_reg[i];
                lad_r_reg[0][i] <= rel6_reg[i];
            end
            lad_m_reg[0] <= m7_next;
        end
    end

    for (genvar j = 0; j < 5; j++)
    begin : g_lad
        localparam int K = 16 >> j;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (|lad_m_reg[j][50:29+K])
                begin
                    lad_m_reg[j+1] <= lad_m_reg[j] >> K;
                    for (int i = 0; i < 3; i++)
                        lad_r_reg[j+1][i] <= lad_r_reg[j][i] >>> K;
                end
                else if (lad_m_reg[j][50:30-K] == '0)
                begin
                    lad_m_reg[j+1] <= lad_m_reg[j] << K;
                    for (int i = 0; i < 3; i++)
                        lad_r_reg[j+1][i] <= lad_r_reg[j][i] <<< K;
                end
                else
                begin
                    lad_m_reg[j+1] <= lad_m_reg[j];
                    for (int i = 0; i < 3; i++)
                        lad_r_reg[j+1][i] <= lad_r_reg[j][i];
                end
            end
        end
    end

    logic [59:0]        sq13_reg [0:2];
    logic signed [30:0] rel13_reg [0:2];
    logic signed [30:0] rel14_reg [0:2];
    logic               dg13_reg, dg14_reg;
    logic [RAD_W-1:0]   sum14_reg;
    logic signed [61:0] sqs [0:2];
    logic signed [30:0] reln [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            reln[i] = lad_r_reg[5][i][30:0];
            sqs[i] = 62'(reln[i]) * 62'(reln[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq13_reg[i] <= sqs[i][59:0];
                rel13_reg[i] <= reln[i];
                rel14_reg[i] <= rel13_reg[i];
            end
            dg13_reg <= (lad_m_reg[5] == '0);
            dg14_reg <= dg13_reg;
            sum14_reg <= RAD_W'(sq13_reg[0]) + RAD_W'(sq13_reg[1]) + RAD_W'(sq13_reg[2]);
        end
    end

    logic [RAD_W-1:0] sq2_rem [0:RT_W];
    logic [RT_W-1:0]  sq2_root [0:RT_W];

    assign sq2_rem[0] = sum14_reg;
    assign sq2_root[0] = '0;

    for (genvar j = 0; j < RT_W; j++)
    begin : g_sq2
        vslerp_sqrt_cell #(.BIT(RT_W - 1 - j)) u_sq (
            .clk      (clk),
            .en       (adv),
            .rem_in   (sq2_rem[j]),
            .root_in  (sq2_root[j]),
            .rem_out  (sq2_rem[j+1]),
            .root_out (sq2_root[j+1])
        );
    end

    logic [93:0]        rel45_bus;
    logic signed [30:0] rel45 [0:2];
    logic               dg45;

    vslerp_delay #(.WIDTH(94), .DEPTH(31)) u_rel_dly (
        .clk (clk),
        .en  (adv),
        .d   ({rel14_reg[0], rel14_reg[1], rel14_reg[2], dg14_reg}),
        .q   (rel45_bus)
    );

    assign rel45[0] = rel45_bus[93:63];
    assign rel45[1] = rel45_bus[62:32];
    assign rel45[2] = rel45_bus[31:1];
    assign dg45 = rel45_bus[0];

    // unit vector: rounded quotient per component
    logic [RAD_W-1:0] num46_reg [0:2];
    logic [RT_W-1:0]  mag46_reg;
    logic [2:0]       neg46_reg;
    logic             dg46_reg;
    logic signed [30:0] ab45 [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            ab45[i] = (rel45[i] < 0) ? -rel45[i] : rel45[i];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num46_reg[i] <= (RAD_W'(ab45[i][29:0]) << 30)
                                + RAD_W'(sq2_root[RT_W] >> 1);
                neg46_reg[i] <= rel45[i] < 0;
            end
            mag46_reg <= sq2_root[RT_W];
            dg46_reg <= dg45;
        end
    end

    logic [RT_W-1:0]  dv_d [0:RT_W];
    logic [RAD_W-1:0] dv_rem [0:RT_W][0:2];
    logic [RT_W-1:0]  dv_q [0:RT_W][0:2];

    assign dv_d[0] = mag46_reg;
    assign dv_rem[0] = num46_reg;
    assign dv_q[0] = '{default: '0};

    for (genvar j = 0; j < RT_W; j++)
    begin : g_div
        vslerp_div_cell #(.BIT(RT_W - 1 - j)) u_div (
            .clk     (clk),
            .en      (adv),
            .dv_in   (dv_d[j]),
            .rem_in  (dv_rem[j]),
            .q_in    (dv_q[j]),
            .dv_out  (dv_d[j+1]),
            .rem_out (dv_rem[j+1]),
            .q_out   (dv_q[j+1])
        );
    end

    logic [3:0] sgn77;

    vslerp_delay #(.WIDTH(4), .DEPTH(31)) u_sgn_dly (
        .clk (clk),
        .en  (adv),
        .d   ({neg46_reg, dg46_reg}),
        .q   (sgn77)
    );

    logic signed [31:0] u78_reg [0:2];
    logic               dg78_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (sgn77[0])
                    u78_reg[i] <= '0;
                else if (sgn77[i+1])
                    u78_reg[i] <= -32'(dv_q[RT_W][i]);
                else
                    u78_reg[i] <= 32'(dv_q[RT_W][i]);
            end
            dg78_reg <= sgn77[0];
        end
    end

    // join both paths with the start vector
    logic [2*CW-1:0] csj_bus;
    logic [96:0]     uj_bus;
    logic [59:0]     sj_bus;

    vslerp_delay #(.WIDTH(2*CW), .DEPTH(JN - LA)) u_cs_dly (
        .clk (clk),
        .en  (adv),
        .d   ({cs_reg, sv_reg}),
        .q   (csj_bus)
    );

    vslerp_delay #(.WIDTH(97), .DEPTH(JN - LR)) u_u_dly (
        .clk (clk),
        .en  (adv),
        .d   ({u78_reg[2], u78_reg[1], u78_reg[0], dg78_reg}),
        .q   (uj_bus)
    );

    vslerp_delay #(.WIDTH(60), .DEPTH(JN - 4)) u_s_dly (
        .clk (clk),
        .en  (adv),
        .d   ({s4_reg[2], s4_reg[1], s4_reg[0]}),
        .q   (sj_bus)
    );

    logic signed [CW-1:0]    csj, svj;
    logic signed [31:0]      uj [0:2];
    logic signed [VEC_W-1:0] sj [0:2];

    assign csj = csj_bus[2*CW-1:CW];
    assign svj = csj_bus[CW-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            uj[i] = uj_bus[i*32+1 +: 32];
            sj[i] = sj_bus[i*VEC_W +: VEC_W];
        end
    end

    logic signed [53:0] p1_reg [0:2];
    logic signed [65:0] p2_reg [0:2];
    logic signed [63:0] acc_reg [0:2];
    logic               dgf1_reg, dgf2_reg;
    res_t               res_reg;
    logic signed [63:0] rnd [0:2];
    logic signed [VEC_W-1:0] satv [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = (acc_reg[i] + 64'sd536870912) >>> 30;
            if (rnd[i] > 64'sd524287)
                satv[i] = 20'sd524287;
            else if (rnd[i] < -64'sd524288)
                satv[i] = -20'sd524288;
            else
                satv[i] = rnd[i][VEC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= 54'(sj[i]) * 54'(csj);
                p2_reg[i] <= 66'(uj[i]) * 66'(svj);
                acc_reg[i] <= 64'(p1_reg[i]) + 64'((p2_reg[i] + 66'sd8192) >>> 14);
            end
            dgf1_reg <= uj_bus[0];
            dgf2_reg <= dgf1_reg;
            res_reg.x <= satv[0];
            res_reg.y <= satv[1];
            res_reg.z <= satv[2];
            res_reg.degen <= dgf2_reg;
        end
    end

    // valid line and output buffer
    res_t       fifo_reg [0:1];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, rd_reg;
    logic       push, pop;

    assign adv = cnt_reg != 2'd2;
    assign s_tready = adv;
    assign push = adv && vld_reg[TOT-1];
    assign pop = m_tvalid && m_tready;
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata = {4'b0, fifo_reg[rd_reg].z, fifo_reg[rd_reg].y, fifo_reg[rd_reg].x};
    assign m_tuser = fifo_reg[rd_reg].degen;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            cnt_reg <= '0;
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[TOT-2:0], s_tvalid};
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_reg] <= res_reg;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while output buffer full");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("buffer count not decremented on read");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[LR-1] && dg78_reg) |->
        (u78_reg[0] == 0 && u78_reg[1] == 0 && u78_reg[2] == 0))
        else $error("degenerate beat with non-zero unit vector");

endmodule
